// ----- hdl/wnm_pkg.sv -----
// Shared constants and types for the wildcard name matcher.
package wnm_pkg;

  // Pattern positions tracked; one more state bit than positions.
  localparam int PATTERN_MAX = 32;
  localparam int NPOS        = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  // Character slots held in registers: four words of eight bytes.
  localparam int CHAR_SLOTS  = 32;
  localparam int WORD_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int LENGTH_W    = 6;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_D = 3'd4;

  // Wildcard characters.
  localparam logic [7:0] CHAR_ANY = 8'h3F; // '?'
  localparam logic [7:0] CHAR_RUN = 8'h2A; // '*'

  typedef logic [NPOS-1:0] positions_t;

  // Pattern as configured: length field and characters, slot 0 lowest.
  typedef struct packed {
    logic [LENGTH_W-1:0]          length;
    logic [CHAR_SLOTS-1:0][7:0]   chars;
  } pattern_t;

endpackage

// ----- hdl/wnm_step.sv -----
// Position-set update for one name character against the pattern.
module wnm_step (
  input  wnm_pkg::pattern_t   pattern,
  input  wnm_pkg::positions_t active,
  input  logic [7:0]          name_char,
  output wnm_pkg::positions_t active_next,
  output logic                match
);
  import wnm_pkg::*;

  logic [LEN_W-1:0]       len_sat;
  logic [PATTERN_MAX-1:0] nonzero;
  logic [PATTERN_MAX-1:0] in_use;
  logic [PATTERN_MAX-1:0] low_mask;
  logic [7:0]             pat_byte [PATTERN_MAX];
  positions_t             end_pos;

  // Saturate the length field to the position count.
  always_comb begin
    if (int'(pattern.length) > PATTERN_MAX) begin
      len_sat = LEN_W'(PATTERN_MAX);
    end else begin
      len_sat = LEN_W'(pattern.length);
    end
  end

  // Fetch pattern bytes; slots past the registers read as zero.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < CHAR_SLOTS) begin
        pat_byte[i] = pattern.chars[i % CHAR_SLOTS];
      end else begin
        pat_byte[i] = 8'h00;
      end
      nonzero[i] = (pat_byte[i] != 8'h00);
    end
  end

  // Mark positions in use: below the length and before the first zero byte.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      low_mask  = {PATTERN_MAX{1'b1}} >> (PATTERN_MAX - 1 - i);
      in_use[i] = (i < int'(len_sat)) && (&(nonzero | ~low_mask));
    end
  end

  // Advance each position; a run already entered keeps absorbing.
  always_comb begin
    active_next[0] = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      active_next[i+1] = in_use[i] &&
        ((active[i] && (pat_byte[i] == CHAR_RUN || pat_byte[i] == CHAR_ANY ||
                        pat_byte[i] == name_char)) ||
         (pat_byte[i] == CHAR_RUN && active[i+1]));
    end
  end

  // Locate the effective pattern end and test the position there.
  always_comb begin
    end_pos[0] = !in_use[0];
    for (int k = 1; k < PATTERN_MAX; k++) begin
      end_pos[k] = in_use[k-1] && !in_use[k];
    end
    end_pos[PATTERN_MAX] = in_use[PATTERN_MAX-1];
    match = end_pos[0] || (|(end_pos[NPOS-1:1] & active_next[NPOS-1:1]));
  end

endmodule

// ----- hdl/wildcard_name_matcher.sv -----
// Flow: an accepted character is registered in the input stage, then its result in the result register.
// Throughput: one character per cycle while results are taken; the position set updates on each advance.
// A stalled result blocks input once the input register holds a beat (in_ready follows out_ready).
// Reset: pattern registers clear to an empty pattern (match everything), the position set
// returns to position zero only, and both pipeline stages empty.
module wildcard_name_matcher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       name_char,
  input  logic                             name_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             matches_res,
  output logic                             name_done,
  input  logic                             cfg_we,
  input  logic [wnm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wnm_pkg::WORD_W-1:0]       cfg_data
);
  import wnm_pkg::*;

  logic [LENGTH_W-1:0] pattern_length;
  logic [WORD_W-1:0]   pattern_words [4];
  pattern_t            pattern;

  logic                s1_valid;
  logic [7:0]          s1_char;
  logic                s1_end;
  logic                s1_advance;

  positions_t          active;
  positions_t          active_next;
  logic                step_match;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length   <= '0;
      pattern_words[0] <= '0;
      pattern_words[1] <= '0;
      pattern_words[2] <= '0;
      pattern_words[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LENGTH:  pattern_length   <= cfg_data[LENGTH_W-1:0];
        REG_CHARS_A: pattern_words[0] <= cfg_data;
        REG_CHARS_B: pattern_words[1] <= cfg_data;
        REG_CHARS_C: pattern_words[2] <= cfg_data;
        REG_CHARS_D: pattern_words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pattern.length = pattern_length;
  assign pattern.chars  = {pattern_words[3], pattern_words[2],
                           pattern_words[1], pattern_words[0]};

  // Pipeline flow: the input stage moves when the result register is free.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= name_char;
      s1_end  <= name_end;
    end
  end

  wnm_step u_step (
    .pattern     (pattern),
    .active      (active),
    .name_char   (s1_char),
    .active_next (active_next),
    .match       (step_match)
  );

  // Update the position set; drop back to the start after the last character.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= NPOS'(1);
    end else if (s1_advance) begin
      if (s1_end) begin
        active <= NPOS'(1);
      end else begin
        active <= active_next;
      end
    end
  end

  // Hold the result beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      matches_res <= step_match;
      name_done   <= s1_end;
    end
  end

endmodule

// ----- hdl/wnm_checker.sv -----
// Port-level checks for the wildcard name matcher and their bind.
module wnm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic matches_res,
  input logic name_done
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(matches_res) && $stable(name_done))
    else $error("result beat changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // An empty result register never blocks input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // An accepted beat reaches the output once the consumer takes.
  a_beat_arrives: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .matches_res (matches_res),
  .name_done   (name_done)
);

// ----- dv/wildcard_name_matcher_test.sv -----
// Testbench for the wildcard name matcher: directed and random names checked beat by beat.
module wildcard_name_matcher_test;
  import wnm_pkg::*;

  typedef logic [CHAR_SLOTS-1:0][7:0] slots_t;

  typedef struct {
    logic matched;
    logic done;
  } verdict_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           name_char;
  logic                 name_end;
  logic                 out_valid;
  logic                 out_ready;
  logic                 matches_res;
  logic                 name_done;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  // Mirror of the pattern registers and the reachable position set
  logic [LENGTH_W-1:0] pat_len;
  slots_t              pat_chars;
  positions_t          reach;

  verdict_t   verdicts_due[$];
  logic [7:0] name_buf[$];
  int         fault_count;
  int         items_sent;
  int         send_idle_pct;
  int         stall_pct;

  wildcard_name_matcher DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .name_char   (name_char),
    .name_end    (name_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .matches_res (matches_res),
    .name_done   (name_done),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pattern length in effect: saturate, then stop at the first zero byte
  function automatic int live_length();
    int n;
    int k;
    n = int'(pat_len);
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    for (k = 0; k < n; k++) begin
      if (k >= CHAR_SLOTS || pat_chars[k] == 8'h00) return k;
    end
    return n;
  endfunction

  // Advance the position set by one name character and give the match verdict
  function automatic verdict_t match_char(input logic [7:0] c, input logic last);
    positions_t nxt;
    logic [7:0] b;
    int         n;
    int         i;
    verdict_t   v;
    n = live_length();
    nxt = '0;
    for (i = 0; i < n; i++) begin
      b = pat_chars[i];
      if (reach[i] && (b == CHAR_RUN || b == CHAR_ANY || b == c)) nxt[i+1] = 1'b1;
      // a star that has taken a character may take more
      if (b == CHAR_RUN && reach[i+1]) nxt[i+1] = 1'b1;
    end
    v.matched = (n == 0) ? 1'b1 : nxt[n];
    v.done = last;
    reach = last ? positions_t'(1) : nxt;
    return v;
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] d);
    case (idx)
      REG_LENGTH:  pat_len = d[LENGTH_W-1:0];
      REG_CHARS_A: pat_chars[7:0] = d;
      REG_CHARS_B: pat_chars[15:8] = d;
      REG_CHARS_C: pat_chars[23:16] = d;
      REG_CHARS_D: pat_chars[31:24] = d;
      default: ;
    endcase
  endfunction

  function automatic slots_t text_slots(input string s);
    slots_t t;
    int     k;
    t = '0;
    for (k = 0; k < s.len() && k < CHAR_SLOTS; k++) t[k] = s[k];
    return t;
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(1, 255));
      2:       return CHAR_ANY;
      3:       return CHAR_RUN;
      default: return 8'h61 + 8'($urandom_range(0, 2));
    endcase
  endfunction

  // Build a name that follows the pattern, broken now and then, or plain noise
  function automatic void compose_name(input bit faithful);
    int         n;
    int         k;
    int         r;
    logic [7:0] b;
    name_buf.delete();
    if (faithful) begin
      n = live_length();
      for (k = 0; k < n; k++) begin
        b = pat_chars[k];
        if (b == CHAR_RUN) repeat ($urandom_range(1, 3)) name_buf.push_back(pick_char());
        else if (b == CHAR_ANY) name_buf.push_back(pick_char());
        else name_buf.push_back(b);
      end
      r = $urandom_range(0, 9);
      if (r == 0 && name_buf.size() > 1) begin
        name_buf.delete($urandom_range(0, name_buf.size() - 1));
      end else if (r == 1) begin
        name_buf.push_back(pick_char());
      end else if (r == 2 && name_buf.size() > 0) begin
        name_buf[$urandom_range(0, name_buf.size() - 1)] = pick_char();
      end
    end else begin
      repeat ($urandom_range(1, 10)) name_buf.push_back(pick_char());
    end
    if (name_buf.size() == 0) name_buf.push_back(pick_char());
  endfunction

  task automatic flag(input string what, input logic exp_v, input logic act_v);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch at %0t: %s expected %b got %b", $time, what, exp_v, act_v);
  endtask

  // Write one register; leave the write enable high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    store_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [WORD_W-1:0] len_word, input slots_t chars);
    write_reg(REG_LENGTH, len_word);
    write_reg(REG_CHARS_A, chars[7:0]);
    write_reg(REG_CHARS_B, chars[15:8]);
    write_reg(REG_CHARS_C, chars[23:16]);
    write_reg(REG_CHARS_D, chars[31:24]);
    cfg_we <= 1'b0;
  endtask

  // Send one character beat; valid is left high so back-to-back beats need no toggle
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    name_char <= c;
    name_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdicts_due.push_back(match_char(c, last));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit finish);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], finish && i == s.len() - 1);
  endtask

  // Hold off input until every result is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic test_reset_pattern();
    settle();
    send_text("ab", 1'b1);
  endtask

  task automatic test_literal_and_any();
    settle();
    load_pattern(64'd4, text_slots("a?c*"));
    send_text("abcd", 1'b1);
    // star needs at least one character
    send_text("abc", 1'b1);
  endtask

  task automatic test_odd_bytes();
    slots_t chars;
    settle();
    load_pattern(64'd1, text_slots("?"));
    send_char(8'h00, 1'b1);
    chars = '0;
    chars[0] = 8'hFF;
    settle();
    load_pattern(64'd1, chars);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_zero_in_pattern();
    slots_t chars;
    chars = text_slots("ab");
    chars[3] = 8'h63;
    chars[4] = 8'h64;
    settle();
    load_pattern(64'd5, chars);
    send_text("ab", 1'b1);
  endtask

  task automatic test_length_limits();
    settle();
    load_pattern(64'hFFFF_FFFF_FFFF_FFFF, text_slots("x*"));
    send_text("xyz", 1'b1);
    settle();
    load_pattern(64'd0, text_slots("zz"));
    send_text("q", 1'b1);
  endtask

  task automatic test_midname_update();
    settle();
    load_pattern(64'd2, text_slots("ab"));
    send_text("a", 1'b0);
    // new pattern applies to the positions already reached
    settle();
    load_pattern(64'd2, text_slots("aX"));
    send_text("X", 1'b1);
  endtask

  task automatic load_random_pattern();
    slots_t            chars;
    int                n;
    int                k;
    int                r;
    logic [WORD_W-1:0] len_word;
    for (k = 0; k < CHAR_SLOTS; k++) chars[k] = 8'($urandom);
    case ($urandom_range(0, 19))
      0:       n = 0;
      1, 2:    n = PATTERN_MAX;
      default: n = $urandom_range(1, 8);
    endcase
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1:    chars[k] = CHAR_ANY;
        2, 3:    chars[k] = CHAR_RUN;
        4:       chars[k] = 8'($urandom_range(1, 255));
        default: chars[k] = 8'h61 + 8'($urandom_range(0, 2));
      endcase
    end
    // cut the pattern short with a zero byte now and then
    if (n > 1 && $urandom_range(0, 9) == 0) chars[$urandom_range(0, n - 1)] = 8'h00;
    len_word = 64'(n);
    r = $urandom_range(0, 9);
    if (r == 0) begin
      len_word[WORD_W-1:LENGTH_W] = 58'({$urandom, $urandom});
    end else if (r == 1 && n == PATTERN_MAX) begin
      len_word = 64'($urandom_range(PATTERN_MAX + 1, 63));
    end
    load_pattern(len_word, chars);
  endtask

  task automatic test_random_names(input int target, input int idle_pct, input int stall);
    int goal;
    int names_left;
    int i;
    int n;
    bit finish;
    settle();
    send_idle_pct = idle_pct;
    stall_pct = stall;
    goal = items_sent + target;
    names_left = 0;
    while (items_sent < goal) begin
      if (names_left == 0) begin
        settle();
        load_random_pattern();
        names_left = $urandom_range(2, 6);
      end
      compose_name($urandom_range(0, 9) < 7);
      finish = ($urandom_range(0, 9) != 0);
      n = name_buf.size();
      for (i = 0; i < n; i++) send_char(name_buf[i], finish && i == n - 1);
      names_left--;
    end
    settle();
  endtask

  // Receiver: stall at the current rate
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each result beat with the oldest verdict due
  initial begin
    verdict_t due;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch at %0t: result beat with nothing due, match %b done %b",
                     $time, matches_res, name_done);
        end else begin
          due = verdicts_due.pop_front();
          if (matches_res !== due.matched) flag("matches_res", due.matched, matches_res);
          if (name_done !== due.done) flag("name_done", due.done, name_done);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    name_char = 8'h00;
    name_end = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_LENGTH;
    cfg_data = '0;
    pat_len = '0;
    pat_chars = '0;
    reach = positions_t'(1);
    fault_count = 0;
    items_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_reset_pattern();
    test_literal_and_any();
    test_odd_bytes();
    test_zero_in_pattern();
    test_length_limits();
    test_midname_update();
    test_random_names(260, 0, 0);
    test_random_names(260, 55, 0);
    test_random_names(260, 0, 55);
    test_random_names(260, 37, 37);

    settle();
    repeat (10) @(negedge clk);
    if (verdicts_due.size() != 0) begin
      fault_count += verdicts_due.size();
      $display("%0d results never arrived", verdicts_due.size());
    end
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/wnm_pkg.sv
hdl/wnm_step.sv
hdl/wildcard_name_matcher.sv
hdl/wnm_checker.sv
dv/wildcard_name_matcher_test.sv
